// ===== rtl/core/pffs_pkg.sv =====
// ---------------------------------------------------------------------------
// pffs_pkg
// Shared types and constants for the page frame free stack: transaction
// payloads, command and status codes, register indexes and the control FSM.
// ---------------------------------------------------------------------------
`default_nettype none

package pffs_pkg;

  // Fixed field widths.
  localparam int ADDR_W  = 40;
  localparam int CMD_W   = 2;
  localparam int STAT_W  = 3;
  localparam int COUNT_W = 16;
  localparam int CFG_IDX_W = 1;

  // Default sizing.
  localparam int MAX_PAGES_DEF  = 32768;
  localparam int PAGE_SHIFT_DEF = 12;

  // Register reset values.
  localparam logic [ADDR_W-1:0] REGION_START_RST = 40'd0;
  localparam logic [ADDR_W-1:0] REGION_END_RST   = 40'd134217728;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] CFG_REGION_START = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_REGION_END   = 1'b1;

  typedef enum logic [CMD_W-1:0] {
    CMD_INIT  = 2'd0,
    CMD_ALLOC = 2'd1,
    CMD_FREE  = 2'd2,
    CMD_NOP   = 2'd3
  } cmd_e;

  typedef enum logic [STAT_W-1:0] {
    ST_OK         = 3'd0,
    ST_NO_PAGE    = 3'd1,
    ST_MISALIGNED = 3'd2,
    ST_OUTSIDE    = 3'd3,
    ST_FULL       = 3'd4
  } status_e;

  typedef enum logic [2:0] {
    S_IDLE,
    S_INIT_CALC,
    S_INIT_FILL,
    S_RESP
  } state_e;

  typedef struct packed {
    logic [CMD_W-1:0]  command;
    logic [ADDR_W-1:0] address;
  } in_t;

  typedef struct packed {
    logic [ADDR_W-1:0]  page_address;
    logic [STAT_W-1:0]  status;
    logic [COUNT_W-1:0] free_count;
  } out_t;

endpackage

`default_nettype wire

// ===== rtl/core/pffs_ram.sv =====
// ---------------------------------------------------------------------------
// pffs_ram
// Single-port synchronous RAM holding the stacked page numbers. One access
// per cycle; read data is registered and valid in the cycle after the read.
// ---------------------------------------------------------------------------
`default_nettype none

module pffs_ram #(
  parameter int DEPTH = pffs_pkg::MAX_PAGES_DEF,
  parameter int WIDTH = pffs_pkg::ADDR_W - pffs_pkg::PAGE_SHIFT_DEF,
  localparam int AW   = $clog2(DEPTH)
) (
  input  wire logic             clk,
  input  wire logic             we,
  input  wire logic             re,
  input  wire logic [AW-1:0]    addr,
  input  wire logic [WIDTH-1:0] wdata,
  output logic      [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port and registered read port share one address.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    if (re) begin
      rdata <= mem[addr];
    end
  end

endmodule

`default_nettype wire

// ===== rtl/core/page_frame_free_stack.sv =====
// ---------------------------------------------------------------------------
// page_frame_free_stack
// Last-in-first-out store of free physical page frames held in one RAM.
// ---------------------------------------------------------------------------
// Usage:
//   in_*  : command transactions (initialize, allocate, free) with valid/ready.
//   out_* : one result transaction per command with valid/ready: the page
//           address of an allocation, a status code and the free page count.
//   cfg_* : write-only region_start / region_end registers, written while idle.
// Timing:
//   Allocate and free do their RAM access, if any, in the acceptance cycle;
//   these and the unused command wait in the response state until the output
//   register is free and load it. Initialize passes through a calculation
//   state, then pushes N pages (at most MAX_PAGES), one RAM entry a cycle.
//   One command is in flight at a time; the single RAM port sets the pace.
// Reset:
//   Synchronous, active low. The stack becomes empty and the registers take
//   their reset values. The RAM contents are not cleared and need not be.
// Stall:
//   The result sits in an output register. A new command is accepted while
//   that result waits; its own result holds in the response state until the
//   output register is free.
// ---------------------------------------------------------------------------
`default_nettype none

module page_frame_free_stack #(
  parameter int MAX_PAGES  = pffs_pkg::MAX_PAGES_DEF,
  parameter int PAGE_SHIFT = pffs_pkg::PAGE_SHIFT_DEF
) (
  input  wire logic                               clk,
  input  wire logic                               rst_n,
  input  wire logic                               in_valid,
  output logic                                    in_ready,
  input  wire pffs_pkg::in_t                      in_data,
  output logic                                    out_valid,
  input  wire logic                               out_ready,
  output pffs_pkg::out_t                          out_data,
  input  wire logic                               cfg_we,
  input  wire logic [pffs_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  wire logic [pffs_pkg::ADDR_W-1:0]        cfg_data
);

  localparam int AW_ADDR = pffs_pkg::ADDR_W;
  localparam int PN_W    = AW_ADDR - PAGE_SHIFT;
  localparam int RS_W    = PN_W + 1;
  localparam int DEPTH_W = $clog2(MAX_PAGES + 1);
  localparam int IDX_W   = $clog2(MAX_PAGES);
  localparam int CMP_W   = (RS_W > DEPTH_W) ? RS_W : DEPTH_W;

  // Registers.
  pffs_pkg::state_e          state_r, state_nxt;
  logic [AW_ADDR-1:0]        region_start_r, region_end_r;
  logic [DEPTH_W-1:0]        depth_r, depth_nxt;
  logic [DEPTH_W-1:0]        fill_left_r, fill_left_nxt;
  logic [PN_W-1:0]           pn_r, pn_nxt;
  logic [RS_W-1:0]           rs_pn_r, rs_pn_nxt;
  logic [pffs_pkg::STAT_W-1:0] res_status_r, res_status_nxt;
  logic                      res_use_rd_r, res_use_rd_nxt;
  logic                      out_valid_r, out_valid_nxt;
  pffs_pkg::out_t            out_data_r, out_data_nxt;

  // RAM port.
  logic              ram_we, ram_re;
  logic [IDX_W-1:0]  ram_addr;
  logic [PN_W-1:0]   ram_wdata, ram_rdata;

  // Helpers.
  logic [RS_W-1:0]   rs_pn;
  logic [PN_W-1:0]   addr_pn;
  logic [PN_W-1:0]   end_pn;
  logic [RS_W-1:0]   pages;
  logic [CMP_W-1:0]  pages_c;
  logic              too_many;
  logic              stack_full;
  logic [DEPTH_W-1:0] depth_dec;
  logic              accept;
  logic              out_free;

  assign in_ready   = (state_r == pffs_pkg::S_IDLE);
  assign accept     = in_valid && in_ready;
  assign out_free   = !out_valid_r || out_ready;
  assign stack_full = (depth_r == DEPTH_W'(MAX_PAGES));
  assign depth_dec  = depth_r - 1'b1;

  // Region start rounded up to a page, as a page number.
  assign rs_pn   = {1'b0, region_start_r[AW_ADDR-1:PAGE_SHIFT]}
                 + RS_W'(|region_start_r[PAGE_SHIFT-1:0]);
  assign addr_pn = in_data.address[AW_ADDR-1:PAGE_SHIFT];
  assign end_pn  = region_end_r[AW_ADDR-1:PAGE_SHIFT];

  // Whole pages between the rounded start and the end of the region.
  assign pages    = (rs_pn_r < {1'b0, end_pn}) ? ({1'b0, end_pn} - rs_pn_r) : '0;
  assign pages_c  = CMP_W'(pages);
  assign too_many = (pages_c > CMP_W'(MAX_PAGES));

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      region_start_r <= pffs_pkg::REGION_START_RST;
      region_end_r   <= pffs_pkg::REGION_END_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        pffs_pkg::CFG_REGION_START: region_start_r <= cfg_data;
        pffs_pkg::CFG_REGION_END:   region_end_r   <= cfg_data;
        default: ;
      endcase
    end
  end

  // Next state.
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      pffs_pkg::S_IDLE: begin
        if (accept) begin
          if (pffs_pkg::cmd_e'(in_data.command) == pffs_pkg::CMD_INIT) begin
            state_nxt = pffs_pkg::S_INIT_CALC;
          end else begin
            state_nxt = pffs_pkg::S_RESP;
          end
        end
      end
      pffs_pkg::S_INIT_CALC: state_nxt = pffs_pkg::S_INIT_FILL;
      pffs_pkg::S_INIT_FILL: begin
        if (fill_left_r == '0) begin
          state_nxt = pffs_pkg::S_RESP;
        end
      end
      pffs_pkg::S_RESP: begin
        if (out_free) begin
          state_nxt = pffs_pkg::S_IDLE;
        end
      end
      default: state_nxt = pffs_pkg::S_IDLE;
    endcase
  end

  // Datapath, RAM control and outputs.
  always_comb begin
    depth_nxt      = depth_r;
    fill_left_nxt  = fill_left_r;
    pn_nxt         = pn_r;
    rs_pn_nxt      = rs_pn_r;
    res_status_nxt = res_status_r;
    res_use_rd_nxt = res_use_rd_r;
    out_valid_nxt  = out_valid_r && !out_ready;
    out_data_nxt   = out_data_r;
    ram_we         = 1'b0;
    ram_re         = 1'b0;
    ram_addr       = depth_r[IDX_W-1:0];
    ram_wdata      = addr_pn;

    unique case (state_r)
      pffs_pkg::S_IDLE: begin
        if (accept) begin
          res_status_nxt = pffs_pkg::ST_OK;
          res_use_rd_nxt = 1'b0;
          unique case (pffs_pkg::cmd_e'(in_data.command))
            pffs_pkg::CMD_INIT: begin
              rs_pn_nxt = rs_pn;
              depth_nxt = '0;
            end
            pffs_pkg::CMD_ALLOC: begin
              if (depth_r == '0) begin
                res_status_nxt = pffs_pkg::ST_NO_PAGE;
              end else begin
                ram_re         = 1'b1;
                ram_addr       = depth_dec[IDX_W-1:0];
                depth_nxt      = depth_dec;
                res_use_rd_nxt = 1'b1;
              end
            end
            pffs_pkg::CMD_FREE: begin
              priority if (in_data.address[PAGE_SHIFT-1:0] != '0) begin
                res_status_nxt = pffs_pkg::ST_MISALIGNED;
              end else if (({1'b0, addr_pn} < rs_pn) ||
                           (in_data.address >= region_end_r)) begin
                res_status_nxt = pffs_pkg::ST_OUTSIDE;
              end else if (stack_full) begin
                res_status_nxt = pffs_pkg::ST_FULL;
              end else begin
                ram_we    = 1'b1;
                depth_nxt = depth_r + 1'b1;
              end
            end
            pffs_pkg::CMD_NOP: ;
            default: ;
          endcase
        end
      end

      pffs_pkg::S_INIT_CALC: begin
        fill_left_nxt  = too_many ? DEPTH_W'(MAX_PAGES) : DEPTH_W'(pages_c);
        res_status_nxt = too_many ? pffs_pkg::ST_FULL : pffs_pkg::ST_OK;
        pn_nxt         = rs_pn_r[PN_W-1:0];
      end

      // One page pushed per cycle, lowest page first.
      pffs_pkg::S_INIT_FILL: begin
        if (fill_left_r != '0) begin
          ram_we        = 1'b1;
          ram_wdata     = pn_r;
          pn_nxt        = pn_r + 1'b1;
          depth_nxt     = depth_r + 1'b1;
          fill_left_nxt = fill_left_r - 1'b1;
        end
      end

      pffs_pkg::S_RESP: begin
        if (out_free) begin
          out_valid_nxt             = 1'b1;
          out_data_nxt.page_address = res_use_rd_r ? {ram_rdata, {PAGE_SHIFT{1'b0}}} : '0;
          out_data_nxt.status       = res_status_r;
          out_data_nxt.free_count   = pffs_pkg::COUNT_W'(depth_r);
        end
      end

      default: ;
    endcase
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= pffs_pkg::S_IDLE;
      depth_r     <= '0;
      fill_left_r <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      depth_r     <= depth_nxt;
      fill_left_r <= fill_left_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    pn_r         <= pn_nxt;
    rs_pn_r      <= rs_pn_nxt;
    res_status_r <= res_status_nxt;
    res_use_rd_r <= res_use_rd_nxt;
    out_data_r   <= out_data_nxt;
  end

  pffs_ram #(
    .DEPTH (MAX_PAGES),
    .WIDTH (PN_W)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .re    (ram_re),
    .addr  (ram_addr),
    .wdata (ram_wdata),
    .rdata (ram_rdata)
  );

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

`default_nettype wire

// ===== rtl/core/pffs_checker.sv =====
// ---------------------------------------------------------------------------
// pffs_checker
// Port-level checks for the page frame free stack, bound to the top level.
// ---------------------------------------------------------------------------
`default_nettype none

module pffs_checker #(
  parameter int PAGE_SHIFT = pffs_pkg::PAGE_SHIFT_DEF
) (
  input wire logic           clk,
  input wire logic           rst_n,
  input wire logic           out_valid,
  input wire logic           out_ready,
  input wire pffs_pkg::out_t out_data
);

  // A stalled result transaction holds its payload.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("result changed while stalled");

  // Only a successful allocation carries a page address.
  a_addr_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_data.status != pffs_pkg::ST_OK) |-> out_data.page_address == '0)
    else $error("page address on a failed transaction");

  // An empty-stack report comes with a zero free count.
  a_empty_count: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_data.status == pffs_pkg::ST_NO_PAGE) |-> out_data.free_count == '0)
    else $error("no free page reported with a nonzero count");

  // Allocated addresses are page aligned.
  a_aligned: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_data.page_address[PAGE_SHIFT-1:0] == '0)
    else $error("allocated address not page aligned");

  // Reset leaves no result pending.
  a_reset: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid after reset");

endmodule

bind page_frame_free_stack pffs_checker #(
  .PAGE_SHIFT (PAGE_SHIFT)
) u_pffs_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .out_data  (out_data)
);

`default_nettype wire

// ===== sim/page_frame_free_stack_checker.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// page_frame_free_stack_checker
// Watches the command, result and register ports of the page frame free
// stack. It keeps its own copy of the free page stack and region registers,
// works out the result of every accepted command, and compares each accepted
// result field by field with the oldest outstanding prediction.
// ---------------------------------------------------------------------------

module page_frame_free_stack_checker #(
  parameter int MAX_PAGES  = pffs_pkg::MAX_PAGES_DEF,
  parameter int PAGE_SHIFT = pffs_pkg::PAGE_SHIFT_DEF
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_valid,
  input  logic                             in_ready,
  input  pffs_pkg::in_t                    in_data,
  input  logic                             out_valid,
  input  logic                             out_ready,
  input  pffs_pkg::out_t                   out_data,
  input  logic                             cfg_we,
  input  logic [pffs_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [pffs_pkg::ADDR_W-1:0]      cfg_data,
  output int                               pending,
  output int                               errors,
  output int                               checked,
  output logic [4:0]                       statuses_seen
);

  import pffs_pkg::*;

  localparam int          PAGE_NUM_W  = ADDR_W - PAGE_SHIFT;
  localparam logic [63:0] PAGE_BYTES  = 64'd1 << PAGE_SHIFT;
  localparam logic [63:0] STORE_PAGES = 64'(MAX_PAGES);

  // Shadow copy of the stack and the region registers.
  logic [PAGE_NUM_W-1:0] page_mem [MAX_PAGES];
  logic [31:0]           held_pages;
  logic [63:0]           region_lo;
  logic [63:0]           region_hi;

  // Results still owed by the block, oldest first.
  out_t       owed_results[$];
  out_t       want;
  int         err_cnt;
  int         match_cnt;
  logic [4:0] seen_mask;

  // Start of the region rounded up to a page boundary, kept wide so that a
  // start near the top of the address space rounds past it.
  function automatic logic [63:0] first_page(input logic [63:0] lo);
    return (lo + PAGE_BYTES - 64'd1) & ~(PAGE_BYTES - 64'd1);
  endfunction

  // Applies one command to the shadow state and returns its result.
  task automatic apply_command(input in_t item, output out_t res);
    logic [63:0] rs;
    logic [63:0] addr;
    logic [63:0] npages;
    logic [63:0] i;
    logic [63:0] pnum;
    res  = '0;
    rs   = first_page(region_lo);
    addr = {24'd0, item.address};
    case (cmd_e'(item.command))
      CMD_INIT: begin
        npages = 64'd0;
        if (rs + PAGE_BYTES <= region_hi) begin
          npages = (region_hi - rs) >> PAGE_SHIFT;
        end
        // Lowest page goes in first so the highest one comes out first.
        for (i = 64'd0; i < npages && i < STORE_PAGES; i++) begin
          pnum = (rs + (i << PAGE_SHIFT)) >> PAGE_SHIFT;
          page_mem[i] = pnum[PAGE_NUM_W-1:0];
        end
        held_pages = (npages > STORE_PAGES) ? MAX_PAGES : npages[31:0];
        if (npages > STORE_PAGES) begin
          res.status = ST_FULL;
        end
      end
      CMD_ALLOC: begin
        if (held_pages == 0) begin
          res.status = ST_NO_PAGE;
        end else begin
          held_pages--;
          res.page_address = {page_mem[held_pages], {PAGE_SHIFT{1'b0}}};
        end
      end
      CMD_FREE: begin
        // Alignment is checked before the bounds, the bounds before capacity.
        if ((addr & (PAGE_BYTES - 64'd1)) != 64'd0) begin
          res.status = ST_MISALIGNED;
        end else if (addr < rs || addr >= region_hi) begin
          res.status = ST_OUTSIDE;
        end else if (held_pages >= MAX_PAGES) begin
          res.status = ST_FULL;
        end else begin
          page_mem[held_pages] = item.address[ADDR_W-1:PAGE_SHIFT];
          held_pages++;
        end
      end
      default: begin
      end
    endcase
    res.free_count = held_pages[COUNT_W-1:0];
  endtask

  // Score results, then predict new commands, then track register writes.
  always @(posedge clk) begin
    if (!rst_n) begin
      held_pages = '0;
      region_lo  = {24'd0, REGION_START_RST};
      region_hi  = {24'd0, REGION_END_RST};
      owed_results.delete();
      err_cnt    = 0;
      match_cnt  = 0;
      seen_mask  = '0;
    end else begin
      if (out_valid && out_ready) begin
        if (owed_results.size() == 0) begin
          err_cnt++;
          $display("%0t: result with none outstanding: expected nothing, actual %h",
                   $time, out_data);
        end else begin
          want = owed_results.pop_front();
          match_cnt++;
          if (out_data.page_address !== want.page_address) begin
            err_cnt++;
            $display("%0t: page_address mismatch: expected %h, actual %h",
                     $time, want.page_address, out_data.page_address);
          end
          if (out_data.status !== want.status) begin
            err_cnt++;
            $display("%0t: status mismatch: expected %0d, actual %0d",
                     $time, want.status, out_data.status);
          end else begin
            seen_mask[want.status] = 1'b1;
          end
          if (out_data.free_count !== want.free_count) begin
            err_cnt++;
            $display("%0t: free_count mismatch: expected %0d, actual %0d",
                     $time, want.free_count, out_data.free_count);
          end
        end
      end
      if (in_valid && in_ready) begin
        apply_command(in_data, want);
        owed_results.push_back(want);
      end
      if (cfg_we) begin
        if (cfg_index == CFG_REGION_START) begin
          region_lo = {24'd0, cfg_data};
        end else begin
          region_hi = {24'd0, cfg_data};
        end
      end
    end
    pending       <= owed_results.size();
    errors        <= err_cnt;
    checked       <= match_cnt;
    statuses_seen <= seen_mask;
  end

endmodule

// ===== sim/page_frame_free_stack_tb.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// page_frame_free_stack_tb
// Drives initialize, allocate and free commands into the page frame free
// stack: a directed pass over the corner cases, then random region settings
// each followed by a burst of mixed commands, under three idling patterns
// and one long result stall. A checker beside the block scores every result.
// ---------------------------------------------------------------------------

module page_frame_free_stack_tb;

  import pffs_pkg::*;

  localparam int          MAX_PAGES        = MAX_PAGES_DEF;
  localparam int          PAGE_SHIFT       = PAGE_SHIFT_DEF;
  localparam logic [63:0] PAGE_BYTES       = 64'd1 << PAGE_SHIFT;
  localparam logic [63:0] TOP_ADDR         = 64'hFF_FFFF_FFFF;
  localparam int          LONG_HOLD        = 300;
  localparam int          HOLD_ITEMS       = 16;
  localparam int          DRAIN_CYCLES     = 8;
  localparam int          RANDOM_PER_PHASE = 500;

  logic                 clk       = 1'b0;
  logic                 rst_n     = 1'b0;
  logic                 in_valid  = 1'b0;
  logic                 in_ready;
  in_t                  in_data   = '0;
  logic                 out_valid;
  logic                 out_ready = 1'b0;
  out_t                 out_data;
  logic                 cfg_we    = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = CFG_REGION_START;
  logic [ADDR_W-1:0]    cfg_data  = '0;

  int         pending;
  int         errors;
  int         checked;
  logic [4:0] statuses_seen;

  int   send_idle_pct = 0;
  int   recv_idle_pct = 0;
  logic hold_req      = 1'b0;
  logic hold_seen     = 1'b0;
  int   hold_left     = 0;
  int   cmds_sent     = 0;
  int   regions_set   = 0;

  page_frame_free_stack #(
    .MAX_PAGES (MAX_PAGES),
    .PAGE_SHIFT(PAGE_SHIFT)
  ) dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_data (out_data),
    .cfg_we   (cfg_we),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data)
  );

  page_frame_free_stack_checker #(
    .MAX_PAGES (MAX_PAGES),
    .PAGE_SHIFT(PAGE_SHIFT)
  ) checker_i (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .in_data      (in_data),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .out_data     (out_data),
    .cfg_we       (cfg_we),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .pending      (pending),
    .errors       (errors),
    .checked      (checked),
    .statuses_seen(statuses_seen)
  );

  // 8 ns clock.
  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // Result side: random back-pressure, plus one long hold-off on request.
  always @(posedge clk) begin
    if (!rst_n) begin
      out_ready <= 1'b0;
      hold_seen <= hold_req;
      hold_left <= 0;
    end else if (hold_req != hold_seen) begin
      hold_seen <= hold_req;
      hold_left <= LONG_HOLD;
      out_ready <= 1'b0;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
      out_ready <= 1'b0;
    end else begin
      out_ready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  // Offers one command transaction and waits until it is taken.
  task automatic issue(input cmd_e cmd, input logic [ADDR_W-1:0] addr);
    if ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < send_idle_pct);
    end
    in_valid <= 1'b1;
    in_data  <= {cmd, addr};
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    cmds_sent++;
  endtask

  // Stops offering commands and waits until every result has come back.
  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // Writes both region registers once the block has gone idle.
  task automatic program_region(input logic [63:0] lo, input logic [63:0] hi);
    drain();
    cfg_we    <= 1'b1;
    cfg_index <= CFG_REGION_START;
    cfg_data  <= lo[ADDR_W-1:0];
    @(posedge clk);
    cfg_index <= CFG_REGION_END;
    cfg_data  <= hi[ADDR_W-1:0];
    @(posedge clk);
    cfg_we    <= 1'b0;
    regions_set++;
  endtask

  // Random small regions, each initialized and then worked with a mix of
  // allocates, in-region frees and the odd bad or unused command.
  task automatic random_traffic(input int n_items);
    int          done_items;
    int          n_ops;
    int          pick;
    int          span;
    logic [63:0] lo;
    logic [63:0] rs;
    logic [63:0] hi;
    logic [63:0] page;
    logic [63:0] noise;
    done_items = 0;
    while (done_items < n_items) begin
      pick = $urandom_range(99);
      span = $urandom_range(0, 40);
      lo   = {$urandom(), $urandom()} & TOP_ADDR;
      if (pick < 60) begin
        lo = lo & ~(PAGE_BYTES - 64'd1);
      end
      // A few regions sit right against the top of the address space.
      if (pick >= 88 && pick < 94) begin
        lo = TOP_ADDR - 64'(span) * PAGE_BYTES - 64'($urandom_range(PAGE_BYTES - 1));
      end
      rs = (lo + PAGE_BYTES - 64'd1) & ~(PAGE_BYTES - 64'd1);
      hi = rs + 64'(span) * PAGE_BYTES;
      if (pick[0]) begin
        hi = hi + 64'($urandom_range(PAGE_BYTES - 1));
      end
      if (hi > TOP_ADDR || (pick >= 88 && pick < 94)) begin
        hi = TOP_ADDR;
      end
      // Empty or inverted regions.
      if (pick >= 94) begin
        hi = (lo > 64'd16384) ? lo - 64'($urandom_range(0, 3)) * PAGE_BYTES : 64'd0;
      end
      program_region(lo, hi);
      issue(CMD_INIT, ADDR_W'($urandom()));
      done_items++;
      n_ops = $urandom_range(8, 50);
      repeat (n_ops) begin
        pick  = $urandom_range(99);
        page  = rs + 64'($urandom_range(0, (span > 0) ? span - 1 : 0)) * PAGE_BYTES;
        noise = {$urandom(), $urandom()} & TOP_ADDR;
        if (pick < 45) begin
          issue(CMD_ALLOC, noise[ADDR_W-1:0]);
        end else if (pick < 85) begin
          issue(CMD_FREE, page[ADDR_W-1:0]);
        end else if (pick < 90) begin
          page = page | 64'($urandom_range(1, PAGE_BYTES - 1));
          issue(CMD_FREE, page[ADDR_W-1:0]);
        end else if (pick < 94) begin
          noise = noise & ~(PAGE_BYTES - 64'd1);
          issue(CMD_FREE, noise[ADDR_W-1:0]);
        end else if (pick < 96) begin
          page = hi & ~(PAGE_BYTES - 64'd1);
          issue(CMD_FREE, page[ADDR_W-1:0]);
        end else if (pick < 98) begin
          issue(CMD_INIT, noise[ADDR_W-1:0]);
        end else begin
          issue(CMD_NOP, noise[ADDR_W-1:0]);
        end
        done_items++;
      end
    end
  endtask

  // Stimulus and verdict.
  initial begin
    repeat (7) @(posedge clk);
    rst_n         <= 1'b1;
    send_idle_pct <= 34;
    recv_idle_pct <= 86;
    @(posedge clk);

    // Reset region: the store starts empty and the region fills it exactly.
    issue(CMD_ALLOC, '0);
    issue(CMD_FREE, 40'h0);
    issue(CMD_ALLOC, '0);
    issue(CMD_NOP, 40'hFF_FFFF_FFFF);
    issue(CMD_INIT, '0);
    issue(CMD_FREE, 40'h2000);
    issue(CMD_FREE, 40'h2001);
    issue(CMD_FREE, 40'h800_0000);
    issue(CMD_FREE, 40'hFF_FFFF_F000);
    issue(CMD_ALLOC, '0);
    issue(CMD_FREE, 40'h7FF_F000);
    // A page freed twice is refused the second time, as the store is full again.
    issue(CMD_FREE, 40'h7FF_F000);

    // Region one page larger than the store, with an unaligned start.
    program_region(64'h1, 64'h1000 + 64'(MAX_PAGES + 1) * PAGE_BYTES + 64'd5);
    issue(CMD_INIT, '0);
    issue(CMD_FREE, 40'h0);
    issue(CMD_ALLOC, '0);

    // Empty region, then an inverted one.
    program_region(64'h5000, 64'h5000);
    issue(CMD_INIT, '0);
    issue(CMD_ALLOC, '0);
    program_region(64'h1_0000, 64'h8000);
    issue(CMD_INIT, '0);
    issue(CMD_FREE, 40'h9000);

    // Start that rounds past the top of the address space.
    program_region(TOP_ADDR, TOP_ADDR);
    issue(CMD_INIT, '0);
    issue(CMD_FREE, 40'hFF_FFFF_F000);

    // Fifteen pages just below the top of the address space.
    program_region(64'hFF_FFFF_0000, TOP_ADDR);
    issue(CMD_INIT, '0);
    issue(CMD_ALLOC, '0);
    issue(CMD_FREE, 40'hFF_FFFF_F000);
    issue(CMD_ALLOC, '0);

    random_traffic(RANDOM_PER_PHASE);
    send_idle_pct <= 86;
    recv_idle_pct <= 34;
    random_traffic(RANDOM_PER_PHASE);
    send_idle_pct <= 0;
    recv_idle_pct <= 0;
    // The result side stalls for a long stretch while commands keep coming,
    // so the block fills up and holds its input off.
    hold_req <= ~hold_req;
    repeat (HOLD_ITEMS) issue(CMD_ALLOC, '0);
    random_traffic(RANDOM_PER_PHASE);
    drain();

    $display("Covered %0d commands over %0d region settings; %0d results checked.",
             cmds_sent, regions_set, checked);
    $display("Status codes returned, one bit per code: %b; one %0d-cycle result stall.",
             statuses_seen, LONG_HOLD);
    if (errors == 0) begin
      $display("page_frame_free_stack_tb: clean");
    end else begin
      $display("page_frame_free_stack_tb: errors");
    end
    $finish;
  end

  // Watchdog.
  initial begin
    #(12_000_000);
    $display("page_frame_free_stack_tb: errors");
    $finish;
  end

endmodule

// ===== files.f =====
rtl/core/pffs_pkg.sv
rtl/core/pffs_ram.sv
rtl/core/page_frame_free_stack.sv
rtl/core/pffs_checker.sv
sim/page_frame_free_stack_checker.sv
sim/page_frame_free_stack_tb.sv
